// File: src/hamming_31_26_stream_encoder_assert.svh
// -----------------------------------------------------------------------------
// Hamming (31,26) stream encoder: assertion macros
// Concurrent checks clocked on clk_i and held off while rst_ni is low.
// -----------------------------------------------------------------------------
`ifndef HAMMING_31_26_STREAM_ENCODER_ASSERT_SVH
`define HAMMING_31_26_STREAM_ENCODER_ASSERT_SVH

// Property must hold at every edge outside reset.
`define H3126_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be seen outside reset.
`define H3126_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: src/h3126_pkg.sv
// -----------------------------------------------------------------------------
// Hamming (31,26) stream encoder package
// Block sizes, the code-bit transfer struct and the codeword builder.
// -----------------------------------------------------------------------------
package h3126_pkg;

  localparam int ByteBits    = 8;
  localparam int DataBits    = 26;
  localparam int CodeBits    = 31;
  localparam int MaxCodeBits = 2 * CodeBits;
  localparam int BufBits     = 80;
  localparam int BufRoom     = BufBits - MaxCodeBits;

  // Code bits produced by one input beat, left aligned, earliest bit in the MSB.
  typedef struct packed {
    logic [MaxCodeBits-1:0] bits;
    logic [5:0]             nbits;
    logic                   last;
  } h3126_code_t;

  // Build a codeword and return it serialized: position 1 in the MSB,
  // position 31 in bit 0.
  function automatic logic [CodeBits-1:0] h3126_encode(input logic [DataBits-1:0] d);
    logic [31:0]         w;
    logic [CodeBits-1:0] s;
    logic                par;
    int                  k;
    w = '0;
    k = 0;
    for (int i = 1; i < 32; i++) begin
      if ((i & (i - 1)) != 0) begin
        w[5'(i)] = d[5'(DataBits - 1 - k)];
        k++;
      end
    end
    for (int p = 0; p < 5; p++) begin
      par = 1'b0;
      for (int i = 1; i < 32; i++) begin
        if (((i >> p) & 1) != 0) begin
          par = par ^ w[5'(i)];
        end
      end
      w[5'(1 << p)] = par;
    end
    for (int j = 0; j < CodeBits; j++) begin
      s[5'(CodeBits - 1 - j)] = w[5'(j + 1)];
    end
    return s;
  endfunction

endpackage

// File: src/h3126_gather.sv
// -----------------------------------------------------------------------------
// Hamming (31,26) data gatherer
// Collects data bits MSB first, encodes full and flushed blocks.
// -----------------------------------------------------------------------------
`include "hamming_31_26_stream_encoder_assert.svh"

module h3126_gather
  import h3126_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output h3126_code_t code_o
);

  logic [DataBits-1:0] data_bits_q, data_bits_d;
  logic [4:0]          data_count_q, data_count_d;

  logic [DataBits+ByteBits-1:0] cat;
  logic [5:0]                   total;
  logic                         full;
  logic [2:0]                   r;
  logic [DataBits-1:0]          blk_a, blk_b, rem_bits;
  logic [4:0]                   rem_cnt;
  logic                         flush;
  logic [CodeBits-1:0]          code_a, code_b;

  always_comb begin
    cat      = {data_bits_q, data_byte_i};
    total    = 6'(data_count_q) + 6'(ByteBits);
    full     = total >= 6'(DataBits);
    r        = 3'(total - 6'(DataBits));
    blk_a    = DataBits'(cat >> r);
    // keep only the bits left over after a completed block, or all of them if none completes
    if (full) begin
      rem_bits = DataBits'(cat) & ((DataBits'(1) << r) - DataBits'(1));
      rem_cnt  = 5'(r);
    end else begin
      rem_bits = DataBits'(cat);
      rem_cnt  = 5'(total);
    end
    blk_b  = rem_bits << (5'(DataBits) - rem_cnt);
    flush  = last_byte_i && (rem_cnt != 5'd0);
    code_a = h3126_encode(blk_a);
    code_b = h3126_encode(blk_b);
  end

  always_comb begin
    code_o.last = last_byte_i;
    case ({full, flush})
      2'b11: begin
        code_o.bits  = {code_a, code_b};
        code_o.nbits = 6'(MaxCodeBits);
      end
      2'b10: begin
        code_o.bits  = {code_a, {CodeBits{1'b0}}};
        code_o.nbits = 6'(CodeBits);
      end
      2'b01: begin
        code_o.bits  = {code_b, {CodeBits{1'b0}}};
        code_o.nbits = 6'(CodeBits);
      end
      default: begin
        code_o.bits  = '0;
        code_o.nbits = 6'd0;
      end
    endcase
  end

  always_comb begin
    data_bits_d  = data_bits_q;
    data_count_d = data_count_q;
    if (accept_i) begin
      if (last_byte_i) begin
        data_bits_d  = '0;
        data_count_d = 5'd0;
      end else begin
        data_bits_d  = rem_bits;
        data_count_d = rem_cnt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_bits_q  <= '0;
      data_count_q <= 5'd0;
    end else begin
      data_bits_q  <= data_bits_d;
      data_count_q <= data_count_d;
    end
  end

  `H3126_ASSERT(a_count_range, data_count_q < 5'(DataBits), "gather count out of range")
  `H3126_ASSERT(a_stale_bits_clear, (data_bits_q >> data_count_q) == '0,
                "gather holds bits above its count")

endmodule

// File: src/h3126_packer.sv
// -----------------------------------------------------------------------------
// Hamming (31,26) output packer
// Bit buffer that appends code bits and drains them one byte per beat.
// -----------------------------------------------------------------------------
`include "hamming_31_26_stream_encoder_assert.svh"

module h3126_packer
  import h3126_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  h3126_code_t code_i,
  output logic        ready_o,
  output logic [7:0]  m_tdata_o,
  output logic        m_tlast_o,
  output logic        m_tvalid_o,
  input  logic        m_tready_i
);

  logic [BufBits-1:0] buf_q, buf_d;
  logic [6:0]         cnt_q, cnt_d;
  logic               last_pend_q, last_pend_d;
  logic [6:0]         last_pos_q, last_pos_d;

  logic               drain;
  logic [6:0]         base, tot, tot_up, padded;
  logic [BufBits-1:0] shifted, ins;
  logic               mark;

  assign m_tvalid_o = cnt_q >= 7'(ByteBits);
  assign m_tdata_o  = buf_q[BufBits-1 -: ByteBits];
  assign m_tlast_o  = last_pend_q && (last_pos_q == 7'(ByteBits));
  assign ready_o    = (cnt_q <= 7'(BufRoom)) && !last_pend_q;
  assign drain      = m_tvalid_o && m_tready_i;

  always_comb begin
    base    = drain ? cnt_q - 7'(ByteBits) : cnt_q;
    shifted = drain ? {buf_q[BufBits-ByteBits-1:0], {ByteBits{1'b0}}} : buf_q;
    ins     = {code_i.bits, {(BufBits - MaxCodeBits){1'b0}}} >> base;
    tot     = base + 7'(code_i.nbits);
    tot_up  = tot + 7'(ByteBits - 1);
    padded  = {tot_up[6:3], 3'b000};
    // a packet end marks a byte only if this beat completes or pads one
    mark    = tot > {base[6:3], 3'b000};

    buf_d       = shifted;
    cnt_d       = base;
    last_pos_d  = (last_pend_q && drain) ? last_pos_q - 7'(ByteBits) : last_pos_q;
    last_pend_d = last_pend_q && !(drain && (last_pos_q == 7'(ByteBits)));
    if (accept_i) begin
      buf_d = shifted | ins;
      if (code_i.last) begin
        cnt_d = padded;
        if (mark) begin
          last_pend_d = 1'b1;
          last_pos_d  = padded;
        end
      end else begin
        cnt_d = tot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q       <= '0;
      cnt_q       <= 7'd0;
      last_pend_q <= 1'b0;
      last_pos_q  <= 7'd0;
    end else begin
      buf_q       <= buf_d;
      cnt_q       <= cnt_d;
      last_pend_q <= last_pend_d;
      last_pos_q  <= last_pos_d;
    end
  end

  `H3126_ASSERT(a_cnt_bound, cnt_q <= 7'(BufBits), "bit buffer overfilled")
  `H3126_ASSERT(a_pend_aligned,
                last_pend_q |-> (cnt_q == last_pos_q) && (last_pos_q[2:0] == 3'b000),
                "packet end not aligned with buffer fill")
  `H3126_ASSERT_NEVER(a_last_not_final, m_tlast_o && (cnt_q != 7'(ByteBits)),
                      "last byte flagged with more bits queued")

endmodule

// File: src/hamming_31_26_stream_encoder.sv
// -----------------------------------------------------------------------------
// Hamming (31,26) stream encoder
// Packs a byte stream into 31-bit Hamming codewords and re-bytes the result.
// -----------------------------------------------------------------------------
// Raw packet bytes come in on the slave stream, MSB first, and every 26 data
// bits become one 31-bit codeword: data fills positions 3..31 skipping the
// powers of two, and parity p covers every position with bit p set. Codewords
// go out on the master stream MSB first, position 1 in bit 7 of the first
// byte. On a beat with tlast high a partial block is zero-padded and encoded,
// the trailing partial byte is zero-padded, and the final byte carries tlast.
// Each input beat is encoded in the cycle it is accepted and its code bits
// (0, 31 or 62) go straight into an 80-bit output buffer, which sends one
// byte per cycle while the receiver is ready. An input beat is taken in any
// cycle in which that buffer holds at most 18 bits and no packet end is
// pending, so input may run one beat per cycle while the output keeps up; in
// steady flow the output port sets the pace, with roughly four output beats
// after each completed block. After a tlast beat, input holds until the final
// byte of the packet has left the buffer.
// -----------------------------------------------------------------------------
module hamming_31_26_stream_encoder
  import h3126_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // slave stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // last_byte
  // master stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] code_byte
  output logic       m_axis_tlast    // last_out
);

  h3126_code_t code;
  logic        in_accept;

  // take a beat only when the buffer can absorb two full codewords and no packet end is pending
  assign in_accept = s_axis_tvalid && s_axis_tready;

  h3126_gather u_gather (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .data_byte_i (s_axis_tdata),
    .last_byte_i (s_axis_tlast),
    .code_o      (code)
  );

  h3126_packer u_packer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_accept),
    .code_i     (code),
    .ready_o    (s_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready)
  );

endmodule

// File: tb/sv/testbench.sv
// -----------------------------------------------------------------------------
// Hamming (31,26) stream encoder testbench
// Drives byte packets into the slave stream and scores every output beat
// against a bit-level encoder model kept in step with accepted input beats.
// -----------------------------------------------------------------------------
// Tests run in turn from one initial block:
//   directed extremes  - single-byte packets, a packet that ends on a block
//                        boundary, a packet with a short trailing block
//   aligned packets    - 26-byte packets whose code bits fill whole bytes,
//                        so no padding byte follows and the last full byte
//                        carries tlast
//   back-pressure      - the receiver holds off for a long stretch while the
//                        sender keeps offering beats, filling the buffer
//   streaming          - back-to-back beats with the receiver always ready
//   random packets     - random lengths and contents, mostly bursty sender,
//                        receiver always ready or with random or patterned stalls
// -----------------------------------------------------------------------------
module testbench
  import h3126_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkHalf     = 5;
  localparam int ResetCycles = 10;
  localparam int TotalBytes  = 460;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 40;
  localparam int HoldOff     = 300;

  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_e;

  // One expected output beat.
  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } code_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;     // [7:0] data_byte
  logic       s_axis_tlast = 1'b0;   // last_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // [7:0] code_byte
  logic       m_axis_tlast;          // last_out

  // Encoder model state.
  logic [DataBits-1:0] gather_bits = '0;
  int                  gather_count = 0;
  bit                  code_bit_fifo[$];
  code_beat_t          code_beats_due[$];

  int       mismatches = 0;
  int       cycle_count = 0;
  int       bytes_sent = 0;
  int       burst_left = 0;
  bit       tx_bursty = 1'b0;
  rx_mode_e rx_mode = RX_ALWAYS;
  int       hold_cycles = 0;
  int       rx_phase = 0;

  hamming_31_26_stream_encoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // Watchdog: abort a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Encoder model
  // ---------------------------------------------------------------------------

  // Build the codeword for one block and return it in send order:
  // position 1 in the MSB, position 31 in bit 0.
  function automatic logic [CodeBits-1:0] hamming_word(input logic [DataBits-1:0] d);
    logic [31:0]         pos_bits;
    logic [CodeBits-1:0] serial;
    logic                par;
    int                  k;
    pos_bits = '0;
    k = DataBits - 1;
    // Data fills every position that is not a power of two, earliest bit first.
    for (int i = 1; i <= CodeBits; i++) begin
      if ((i & (i - 1)) != 0) begin
        pos_bits[i] = d[k];
        k--;
      end
    end
    // Parity 2^p covers every position whose index has bit p set.
    for (int p = 0; p < 5; p++) begin
      par = 1'b0;
      for (int i = 1; i <= CodeBits; i++) begin
        if (((i >> p) & 1) != 0) par = par ^ pos_bits[i];
      end
      pos_bits[1 << p] = par;
    end
    for (int i = 1; i <= CodeBits; i++) serial[CodeBits - i] = pos_bits[i];
    return serial;
  endfunction

  // Append one codeword to the bit FIFO and cut whole bytes off its head.
  task automatic queue_codeword(input logic [DataBits-1:0] d, inout int nbeats);
    logic [CodeBits-1:0] word;
    code_beat_t          beat;
    word = hamming_word(d);
    for (int i = CodeBits - 1; i >= 0; i--) code_bit_fifo.push_back(word[i]);
    while (code_bit_fifo.size() >= ByteBits) begin
      for (int b = ByteBits - 1; b >= 0; b--) beat.code[b] = code_bit_fifo.pop_front();
      beat.last = 1'b0;
      code_beats_due.push_back(beat);
      nbeats++;
    end
  endtask

  // Advance the model by one accepted input beat.
  task automatic predict_code_beats(input logic [7:0] data_byte, input logic last_byte);
    int         nbeats;
    int         nleft;
    code_beat_t beat;
    nbeats = 0;
    for (int b = 7; b >= 0; b--) begin
      gather_bits = {gather_bits[DataBits-2:0], data_byte[b]};
      gather_count++;
      if (gather_count == DataBits) begin
        queue_codeword(gather_bits, nbeats);
        gather_bits = '0;
        gather_count = 0;
      end
    end
    if (last_byte) begin
      // Pad a short trailing block with zeros.
      if (gather_count > 0) begin
        queue_codeword(gather_bits << (DataBits - gather_count), nbeats);
      end
      if (code_bit_fifo.size() > 0) begin
        // Leftover code bits go in the high bits of one more byte.
        nleft = code_bit_fifo.size();
        beat.code = '0;
        for (int b = 7; b > 7 - nleft; b--) beat.code[b] = code_bit_fifo.pop_front();
        beat.last = 1'b1;
        code_beats_due.push_back(beat);
      end else if (nbeats > 0) begin
        // Bytes came out even: mark the newest one.
        beat = code_beats_due.pop_back();
        beat.last = 1'b1;
        code_beats_due.push_back(beat);
      end
      gather_bits = '0;
      gather_count = 0;
      code_bit_fifo.delete();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got 0x%0h, want 0x%0h", cycle_count, what, got, want);
    mismatches++;
  endtask

  // Model input beats and score output beats on the same edge; outputs for
  // a beat accepted at this edge cannot appear before the next one.
  always @(posedge clk_i) begin
    code_beat_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) predict_code_beats(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (code_beats_due.size() == 0) begin
          report_mismatch("unexpected beat, code_byte", m_axis_tdata, 0);
        end else begin
          want = code_beats_due.pop_front();
          if (m_axis_tdata !== want.code) report_mismatch("code_byte", m_axis_tdata, want.code);
          if (m_axis_tlast !== want.last) report_mismatch("last_out", m_axis_tlast, want.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall per mode, with a long hold-off counted down here
  // ---------------------------------------------------------------------------
  localparam logic [6:0] RxPattern = 7'b1011001;

  always @(negedge clk_i) begin
    rx_phase = (rx_phase + 1) % 7;
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles--;
    end else begin
      case (rx_mode)
        RX_ALWAYS:  m_axis_tready <= 1'b1;
        RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 3) != 0);
        default:    m_axis_tready <= RxPattern[rx_phase];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one beat and hold it until accepted. In bursty mode open each
  // burst with a gap.
  task automatic send_byte(input logic [7:0] data_byte, input logic last_byte);
    int gap;
    gap = 0;
    if (tx_bursty) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data_byte;
    s_axis_tlast  <= last_byte;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // Drop valid after the final beat so it is not taken twice.
  task automatic release_tx();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic send_packet(input int nbytes);
    for (int i = 0; i < nbytes; i++) send_byte(8'($urandom), i == nbytes - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed_extremes();
    logic [7:0] pattern [13];
    pattern = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'h80, 8'h01, 8'h7F,
                8'hFE, 8'hF0, 8'h0F, 8'hC3, 8'h3C, 8'hFF};
    tx_bursty = 1'b0;
    rx_mode = RX_ALWAYS;
    // Single-byte packets: a short block padded out to 26 bits.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // 13 bytes make exactly four blocks: no extra block at the end.
    for (int i = 0; i < 13; i++) send_byte(pattern[i], i == 12);
    // 4 bytes: one full block then a 6-bit partial block.
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFE, 1'b1);
    release_tx();
  endtask

  task automatic test_aligned_packets();
    // 26 bytes give eight codewords = 31 whole bytes, no padding byte.
    tx_bursty = 1'b1;
    rx_mode = RX_RANDOM;
    send_packet(26);
    rx_mode = RX_PATTERN;
    send_packet(26);
    release_tx();
  endtask

  task automatic test_back_pressure();
    tx_bursty = 1'b0;
    rx_mode = RX_RANDOM;
    @(posedge clk_i);
    hold_cycles = HoldOff;
    // Keep offering while the output is held: the buffer fills and stalls.
    send_packet(25);
    send_packet(15);
    release_tx();
  endtask

  task automatic test_streaming();
    tx_bursty = 1'b0;
    rx_mode = RX_ALWAYS;
    send_packet(17);
    send_packet(13);
    release_tx();
  endtask

  task automatic test_random_packets();
    int nbytes;
    while (bytes_sent < TotalBytes) begin
      if ($urandom_range(0, 3) == 0) nbytes = 13 * $urandom_range(1, 4);
      else nbytes = $urandom_range(1, 30);
      if (nbytes > TotalBytes - bytes_sent) nbytes = TotalBytes - bytes_sent;
      tx_bursty = ($urandom_range(0, 4) != 0);
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      send_packet(nbytes);
    end
    release_tx();
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_extremes();
    test_aligned_packets();
    test_back_pressure();
    test_streaming();
    test_random_packets();

    // Wait out every expected beat, then watch for strays.
    rx_mode = RX_RANDOM;
    while (code_beats_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
